FILE: hw/rtl/rs3eq_pkg.sv
`default_nettype none

package rs3eq_pkg;

    localparam int STATE_BITS_DEF = 34;
    localparam int MAX_RUN_DEF    = 8;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int STEP_W     = 19;
    localparam int PHASE_W    = 20;
    localparam int BAND_W     = 47;
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_SHIFT = 30;
    localparam int HIST_DEPTH = 3;
    localparam int CHAIN_LEN  = 4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [PHASE_W-1:0] PHASE_ONE     = 20'h10000;
    localparam logic [STEP_W-1:0]  STEP_RST      = 19'd65536;
    localparam logic [COEF_W-1:0]  LOW_COEF_RST  = 16'd7545;
    localparam logic [COEF_W-1:0]  HIGH_COEF_RST = 16'd42140;
    localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd16384;

    typedef enum logic [2:0] {
        REG_ENABLE,
        REG_STEP,
        REG_LOW_COEF,
        REG_HIGH_COEF,
        REG_LOW_GAIN,
        REG_MID_GAIN,
        REG_HIGH_GAIN
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_POLE_LOAD,
        ST_POLE_MUL,
        ST_POLE_WB,
        ST_BAND,
        ST_GAIN_LOAD,
        ST_GAIN_MUL,
        ST_OUT_CALC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       run_end;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/resampler_with_three_band_eq.sv
// a bypassed frame goes from ST_IDLE to ST_EMIT and leaves unchanged through the output register
// an equalized output runs per channel 8 pole updates and 3 band gains
// on the bit-serial shift-add multiplier
// a frame gives up to MAX_RUN outputs, and src_stall holds off further frames until it is done
// reset: poles, history and phase cleared, registers at their reset values
`default_nettype none

module resampler_with_three_band_eq
    import rs3eq_pkg::*;
#(
    parameter int STATE_BITS = STATE_BITS_DEF,
    parameter int MAX_RUN    = MAX_RUN_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  frame_t            src_data,
    output logic              dst_valid,
    input  logic              dst_stall,
    output result_t           dst_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IW     = (STATE_BITS > 32) ? STATE_BITS : 32;
    localparam int DW     = IW + 1;
    localparam int AW     = (IW + 18 > 66) ? IW + 18 : 66;
    localparam int RW     = IW + 1;
    localparam int CW     = ((RW > BAND_W) ? RW : BAND_W) + 1;
    localparam int QW     = AW - GAIN_SHIFT;
    localparam int CNT_W  = $clog2(MAX_RUN + 1);
    localparam int BIT_W  = $clog2(COEF_W);
    localparam int NPOLE  = 4 * CHAIN_LEN;
    localparam int NHIST  = 2 * HIST_DEPTH;
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COEF_W - 1);
    localparam logic signed [CW-1:0] BAND_MAX = CW'(64'sh0000_2000_0000_0000);
    localparam logic signed [CW-1:0] BAND_MIN = -BAND_MAX;

    function automatic logic signed [BAND_W-1:0] clamp_band(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            if (v > BAND_MAX)
            begin
                r = BAND_MAX;
            end
            else if (v < BAND_MIN)
            begin
                r = BAND_MIN;
            end
            else
            begin
                r = v;
            end
            clamp_band = r[BAND_W-1:0];
        end
    endfunction

    state_t state_reg, state_next;

    logic                       enable_reg, enable_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [COEF_W-1:0]          low_coef_reg, low_coef_next;
    logic [COEF_W-1:0]          high_coef_reg, high_coef_next;
    logic [GAIN_W-1:0]          low_gain_reg, low_gain_next;
    logic [GAIN_W-1:0]          mid_gain_reg, mid_gain_next;
    logic [GAIN_W-1:0]          high_gain_reg, high_gain_next;

    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    frame_t                     frame_reg, frame_next;
    logic                       bypass_reg, bypass_next;
    logic                       ch_reg, ch_next;
    logic                       chain_reg, chain_next;
    logic [1:0]                 stage_reg, stage_next;
    logic signed [IW-1:0]       in_reg, in_next;
    logic signed [STATE_BITS-1:0] l_reg, l_next;
    logic signed [BAND_W-1:0]   band_reg [3];
    logic signed [BAND_W-1:0]   band_next [3];
    logic [1:0]                 bsel_reg, bsel_next;
    logic signed [AW-1:0]       acc_reg, acc_next;
    logic signed [AW-1:0]       mcand_reg, mcand_next;
    logic [COEF_W-1:0]          mult_reg, mult_next;
    logic [BIT_W-1:0]           bit_reg, bit_next;
    result_t                    res_reg, res_next;
    logic                       out_valid_reg, out_valid_next;
    result_t                    out_data_reg, out_data_next;

    logic signed [STATE_BITS-1:0] pole_reg [NPOLE];
    logic signed [SAMPLE_W-1:0]   hist_reg [NHIST];

    logic                       accept;
    logic                       cfg_write;
    logic                       out_free;
    logic                       pole_we;
    logic                       hist_shift;
    logic [3:0]                 pole_idx;
    logic [2:0]                 hist_base;
    logic signed [STATE_BITS-1:0] pole_rd;
    logic signed [STATE_BITS-1:0] pole_new;
    logic signed [DW-1:0]       pole_diff;
    logic signed [AW-1:0]       pole_sum;
    logic signed [SAMPLE_W-1:0] cur_sample;
    logic signed [31:0]         x32;
    logic signed [31:0]         d32;
    logic signed [IW-1:0]       x_in;
    logic signed [RW-1:0]       h_raw;
    logic signed [RW-1:0]       m_raw;
    logic [GAIN_W-1:0]          gain_sel;
    logic [QW-1:0]              q_full;
    logic signed [SAMPLE_W-1:0] q_out;
    logic [PHASE_W-1:0]         phase_adv;
    logic [CNT_W-1:0]           count_inc;
    logic                       run_last;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign dst_valid = out_valid_reg;
    assign dst_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !dst_stall;

    // register read
    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_ENABLE:    prdata = DATA_W'(enable_reg);
            REG_STEP:      prdata = DATA_W'(step_reg);
            REG_LOW_COEF:  prdata = DATA_W'(low_coef_reg);
            REG_HIGH_COEF: prdata = DATA_W'(high_coef_reg);
            REG_LOW_GAIN:  prdata = DATA_W'(low_gain_reg);
            REG_MID_GAIN:  prdata = DATA_W'(mid_gain_reg);
            REG_HIGH_GAIN: prdata = DATA_W'(high_gain_reg);
            default:       prdata = '0;
        endcase
    end

    // register write
    always_comb
    begin
        enable_next    = enable_reg;
        step_next      = step_reg;
        low_coef_next  = low_coef_reg;
        high_coef_next = high_coef_reg;
        low_gain_next  = low_gain_reg;
        mid_gain_next  = mid_gain_reg;
        high_gain_next = high_gain_reg;
        if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_ENABLE:    enable_next    = pwdata[0];
                REG_STEP:      step_next      = pwdata[STEP_W-1:0];
                REG_LOW_COEF:  low_coef_next  = pwdata[COEF_W-1:0];
                REG_HIGH_COEF: high_coef_next = pwdata[COEF_W-1:0];
                REG_LOW_GAIN:  low_gain_next  = pwdata[GAIN_W-1:0];
                REG_MID_GAIN:  mid_gain_next  = pwdata[GAIN_W-1:0];
                REG_HIGH_GAIN: high_gain_next = pwdata[GAIN_W-1:0];
                default:       enable_next    = enable_reg;
            endcase
        end
    end

    // shared arithmetic
    always_comb
    begin
        pole_idx   = {chain_reg, ch_reg, stage_reg};
        pole_rd    = pole_reg[pole_idx];
        pole_diff  = DW'(in_reg) - DW'(pole_rd);
        pole_sum   = AW'(pole_rd) + (acc_reg >>> FRAC_BITS);
        if ((&pole_sum[AW-1:STATE_BITS-1]) || !(|pole_sum[AW-1:STATE_BITS-1]))
        begin
            pole_new = pole_sum[STATE_BITS-1:0];
        end
        else if (pole_sum[AW-1])
        begin
            pole_new = {1'b1, {(STATE_BITS-1){1'b0}}};
        end
        else
        begin
            pole_new = {1'b0, {(STATE_BITS-1){1'b1}}};
        end

        cur_sample = ch_reg ? frame_reg.right_sample : frame_reg.left_sample;
        x32        = {cur_sample, 16'h0000};
        x_in       = IW'(x32);
        hist_base  = ch_reg ? 3'(HIST_DEPTH) : 3'd0;
        d32        = {hist_reg[3'(hist_base + 3'(HIST_DEPTH - 1))], 16'h0000};
        h_raw      = RW'(d32) - RW'(in_reg);
        m_raw      = RW'(in_reg) - RW'(l_reg);

        case (bsel_reg)
            2'd0:    gain_sel = low_gain_reg;
            2'd1:    gain_sel = mid_gain_reg;
            default: gain_sel = high_gain_reg;
        endcase

        // truncation toward zero, then saturation
        q_full = acc_reg[AW-1:GAIN_SHIFT]
               + QW'(acc_reg[AW-1] && (|acc_reg[GAIN_SHIFT-1:0]));
        if ((&q_full[QW-1:SAMPLE_W-1]) || !(|q_full[QW-1:SAMPLE_W-1]))
        begin
            q_out = q_full[SAMPLE_W-1:0];
        end
        else if (q_full[QW-1])
        begin
            q_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            q_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end

        phase_adv = phase_reg + PHASE_W'(step_reg);
        count_inc = CNT_W'(count_reg + 1'b1);
        run_last  = !((phase_adv < PHASE_ONE) && (count_inc < CNT_W'(MAX_RUN)));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (src_valid)
                begin
                    state_next = enable_reg ? ST_CHECK : ST_EMIT;
                end
            end
            ST_CHECK:
            begin
                if ((phase_reg < PHASE_ONE) && (count_reg < CNT_W'(MAX_RUN)))
                begin
                    state_next = ST_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_START:     state_next = ST_POLE_LOAD;
            ST_POLE_LOAD: state_next = ST_POLE_MUL;
            ST_POLE_MUL:
            begin
                if (bit_reg == BIT_LAST)
                begin
                    state_next = ST_POLE_WB;
                end
            end
            ST_POLE_WB:
            begin
                if (chain_reg && (stage_reg == 2'(CHAIN_LEN - 1)))
                begin
                    state_next = ST_BAND;
                end
                else
                begin
                    state_next = ST_POLE_LOAD;
                end
            end
            ST_BAND:      state_next = ST_GAIN_LOAD;
            ST_GAIN_LOAD: state_next = ST_GAIN_MUL;
            ST_GAIN_MUL:
            begin
                if (bit_reg == BIT_LAST)
                begin
                    state_next = (bsel_reg == 2'd2) ? ST_OUT_CALC : ST_GAIN_LOAD;
                end
            end
            ST_OUT_CALC:  state_next = ch_reg ? ST_EMIT : ST_START;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = bypass_reg ? ST_IDLE : ST_CHECK;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        src_stall  = (state_reg != ST_IDLE);
        accept     = (state_reg == ST_IDLE) && src_valid;
        pole_we    = (state_reg == ST_POLE_WB);
        hist_shift = (state_reg == ST_BAND);
    end

    // datapath
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        frame_next     = frame_reg;
        bypass_next    = bypass_reg;
        ch_next        = ch_reg;
        chain_next     = chain_reg;
        stage_next     = stage_reg;
        in_next        = in_reg;
        l_next         = l_reg;
        band_next      = band_reg;
        bsel_next      = bsel_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mult_next      = mult_reg;
        bit_next       = bit_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && dst_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    frame_next  = src_data;
                    count_next  = '0;
                    ch_next     = 1'b0;
                    bypass_next = !enable_reg;
                    res_next.left_out  = src_data.left_sample;
                    res_next.right_out = src_data.right_sample;
                    res_next.run_end   = 1'b1;
                end
            end
            ST_CHECK:
            begin
                ch_next = 1'b0;
                if (!((phase_reg < PHASE_ONE) && (count_reg < CNT_W'(MAX_RUN))))
                begin
                    phase_next = (phase_reg >= PHASE_ONE) ? PHASE_W'(phase_reg - PHASE_ONE)
                                                         : '0;
                end
            end
            ST_START:
            begin
                chain_next = 1'b0;
                stage_next = '0;
                in_next    = x_in;
            end
            ST_POLE_LOAD:
            begin
                mcand_next = AW'(pole_diff);
                mult_next  = chain_reg ? high_coef_reg : low_coef_reg;
                acc_next   = AW'(1 << (FRAC_BITS - 1));
                bit_next   = '0;
            end
            ST_POLE_MUL, ST_GAIN_MUL:
            begin
                if (mult_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = mcand_reg <<< 1;
                mult_next  = mult_reg >> 1;
                bit_next   = BIT_W'(bit_reg + 1'b1);
                if ((state_reg == ST_GAIN_MUL) && (bit_reg == BIT_LAST))
                begin
                    bsel_next = 2'(bsel_reg + 2'd1);
                end
            end
            ST_POLE_WB:
            begin
                in_next = IW'(pole_new);
                if (stage_reg == 2'(CHAIN_LEN - 1))
                begin
                    if (!chain_reg)
                    begin
                        l_next     = pole_new;
                        chain_next = 1'b1;
                        stage_next = '0;
                        in_next    = x_in;
                    end
                end
                else
                begin
                    stage_next = 2'(stage_reg + 2'd1);
                end
            end
            ST_BAND:
            begin
                band_next[0] = clamp_band(CW'(l_reg));
                band_next[1] = clamp_band(CW'(m_raw));
                band_next[2] = clamp_band(CW'(h_raw));
                bsel_next    = '0;
                acc_next     = '0;
            end
            ST_GAIN_LOAD:
            begin
                mcand_next = AW'(band_reg[bsel_reg]);
                mult_next  = gain_sel;
                bit_next   = '0;
            end
            ST_OUT_CALC:
            begin
                if (!ch_reg)
                begin
                    res_next.left_out = q_out;
                    ch_next           = 1'b1;
                end
                else
                begin
                    res_next.right_out = q_out;
                    res_next.run_end   = run_last;
                    phase_next         = phase_adv;
                    count_next         = count_inc;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                bsel_next = bsel_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            step_reg      <= STEP_RST;
            low_coef_reg  <= LOW_COEF_RST;
            high_coef_reg <= HIGH_COEF_RST;
            low_gain_reg  <= GAIN_RST;
            mid_gain_reg  <= GAIN_RST;
            high_gain_reg <= GAIN_RST;
            phase_reg     <= '0;
            count_reg     <= '0;
            bypass_reg    <= 1'b0;
            ch_reg        <= 1'b0;
            chain_reg     <= 1'b0;
            stage_reg     <= '0;
            bsel_reg      <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            step_reg      <= step_next;
            low_coef_reg  <= low_coef_next;
            high_coef_reg <= high_coef_next;
            low_gain_reg  <= low_gain_next;
            mid_gain_reg  <= mid_gain_next;
            high_gain_reg <= high_gain_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            bypass_reg    <= bypass_next;
            ch_reg        <= ch_next;
            chain_reg     <= chain_next;
            stage_reg     <= stage_next;
            bsel_reg      <= bsel_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        frame_reg    <= frame_next;
        in_reg       <= in_next;
        l_reg        <= l_next;
        band_reg     <= band_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mult_reg     <= mult_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // pole and history storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPOLE; i++)
            begin
                pole_reg[i] <= '0;
            end
            for (int j = 0; j < NHIST; j++)
            begin
                hist_reg[j] <= '0;
            end
        end
        else
        begin
            if (pole_we)
            begin
                pole_reg[pole_idx] <= pole_new;
            end
            if (hist_shift)
            begin
                hist_reg[3'(hist_base + 3'd2)] <= hist_reg[3'(hist_base + 3'd1)];
                hist_reg[3'(hist_base + 3'd1)] <= hist_reg[hist_base];
                hist_reg[hist_base]            <= cur_sample;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RUN))
        else $error("output count beyond limit");

    a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !phase_reg[PHASE_W-1])
        else $error("phase out of range between frames");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> (state_reg != ST_IDLE))
        else $error("transaction taken without work started");

    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free) |=> out_valid_reg)
        else $error("result not loaded into output register");

endmodule

`default_nettype wire
